>>> hw/rtl/svim_pkg.sv
`timescale 1ns / 1ps

package svim_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned EXIT_LIM_W = 10;
    localparam int unsigned EXIT_CNT_W = 11;
    localparam int unsigned VOLTS_W = 4;
    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [SAMPLE_W-1:0]   HIGH_THR_RST = 12'd834;
    localparam logic [SAMPLE_W-1:0]   LOW_THR_RST  = 12'd237;
    localparam logic [SAMPLE_W-1:0]   MASK_THR_RST = 12'd514;
    localparam logic [EXIT_LIM_W-1:0] EXIT_LIM_RST = 10'd600;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HIGH_THR = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_MASK_THR = 2'd2,
        CFG_EXIT_LIM = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic over;
        logic under;
        logic mask;
    } t_volt_flags;

    typedef struct packed {
        logic on;
        logic off_seen;
    } t_ign_flags;

endpackage

>>> hw/rtl/svim_volt_mon.sv
`timescale 1ns / 1ps

module svim_volt_mon
    import svim_pkg::*;
#(
    parameter int unsigned VOLT_WINDOW = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [SAMPLE_W-1:0]   i_high_thr,
    input  logic [SAMPLE_W-1:0]   i_low_thr,
    input  logic [SAMPLE_W-1:0]   i_mask_thr,
    input  logic [EXIT_LIM_W-1:0] i_exit_lim,
    output t_volt_flags           o_flags
);

    logic [VOLT_WINDOW-1:0] r_over_hist, n_over_hist;
    logic [VOLT_WINDOW-1:0] r_under_hist, n_under_hist;
    logic [VOLT_WINDOW-1:0] r_mask_hist, n_mask_hist;
    logic [EXIT_CNT_W-1:0]  r_exit_cnt, n_exit_cnt;
    t_volt_flags            r_flags, n_flags;
    logic [EXIT_CNT_W-1:0]  lim_ext;
    logic                   in_mask;

    assign lim_ext = {1'b0, i_exit_lim};
    assign in_mask = (i_sample <= i_mask_thr);

    always_comb begin
        n_over_hist  = {r_over_hist[VOLT_WINDOW-2:0], i_sample > i_high_thr};
        n_under_hist = {r_under_hist[VOLT_WINDOW-2:0], i_sample < i_low_thr};
        n_mask_hist  = {r_mask_hist[VOLT_WINDOW-2:0], in_mask};

        // count saturates at limit + 1
        n_exit_cnt = r_exit_cnt;
        if (in_mask) begin
            n_exit_cnt = '0;
        end else if (r_exit_cnt <= lim_ext) begin
            n_exit_cnt = r_exit_cnt + EXIT_CNT_W'(1);
        end

        n_flags = r_flags;
        if (&n_over_hist) begin
            n_flags.over = 1'b1;
        end else if (~|n_over_hist) begin
            n_flags.over = 1'b0;
        end
        if (&n_under_hist) begin
            n_flags.under = 1'b1;
        end else if (~|n_under_hist) begin
            n_flags.under = 1'b0;
        end
        // window set first, exit clear wins
        if (&n_mask_hist) begin
            n_flags.mask = 1'b1;
        end
        if (n_exit_cnt >= lim_ext) begin
            n_flags.mask = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_hist  <= '0;
            r_under_hist <= '0;
            r_mask_hist  <= '0;
            r_exit_cnt   <= '0;
            r_flags      <= '{over: 1'b0, under: 1'b0, mask: 1'b1};
        end else if (i_en) begin
            r_over_hist  <= n_over_hist;
            r_under_hist <= n_under_hist;
            r_mask_hist  <= n_mask_hist;
            r_exit_cnt   <= n_exit_cnt;
            r_flags      <= n_flags;
        end
    end

    assign o_flags = n_flags;

    a_exit_clears_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && n_exit_cnt >= lim_ext) |=> !r_flags.mask)
        else $error("mask flag still set after exit count reached limit");

    a_mask_sample_zeroes_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && in_mask) |=> (r_exit_cnt == '0))
        else $error("exit count not cleared by mask-region sample");

endmodule

>>> hw/rtl/svim_ign_mon.sv
`timescale 1ns / 1ps

module svim_ign_mon
    import svim_pkg::*;
#(
    parameter int unsigned IG_WINDOW = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_level,
    output t_ign_flags o_flags
);

    logic [IG_WINDOW-1:0] r_hist, n_hist;
    logic                 r_latched, n_latched;
    t_ign_flags           r_flags, n_flags;

    always_comb begin
        n_hist    = {r_hist[IG_WINDOW-2:0], i_level};
        n_latched = r_latched;
        n_flags   = r_flags;
        if (&n_hist) begin
            n_latched  = 1'b1;
            n_flags.on = 1'b1;
        end else if (~|n_hist) begin
            n_flags.on = 1'b0;
            if (r_latched) begin
                n_latched        = 1'b0;
                n_flags.off_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= '0;
            r_latched <= 1'b0;
            r_flags   <= '0;
        end else if (i_en) begin
            r_hist    <= n_hist;
            r_latched <= n_latched;
            r_flags   <= n_flags;
        end
    end

    assign o_flags = n_flags;

    a_full_window_sets_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (&n_hist)) |=> (r_flags.on && r_latched))
        else $error("ignition on not set after full high window");

    a_off_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.off_seen |=> r_flags.off_seen)
        else $error("ignition off flag cleared without reset");

endmodule

>>> hw/rtl/supply_voltage_and_ignition_monitor_unit.sv
// Path: an item accepted into the input register is evaluated in one pass and
// lands in the result register when it advances; m_axis_tvalid rises with that load.
// Throughput: 1 item per cycle unless m_axis_tready stalls; single in/out register pair.
// Reset (synchronous, active low): histories and counters cleared, mask flag set,
// thresholds back to 834 / 237 / 514 and exit limit to 600.
`timescale 1ns / 1ps

module supply_voltage_and_ignition_monitor_unit
    import svim_pkg::*;
#(
    parameter int unsigned VOLT_WINDOW = 20,
    parameter int unsigned IG_WINDOW   = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SAMPLE_W-1:0]   i_cfg_wdata,
    // input item
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // adc_sample[11:0], ig_level[12], zero pad
    // result item
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata   // volts[3:0], over_voltage[4],
                                                 // under_voltage[5], mask_flag[6],
                                                 // ig_on[7], ig_off_seen[8], zero pad
);

    logic [SAMPLE_W-1:0]   r_high_thr, r_low_thr, r_mask_thr;
    logic [EXIT_LIM_W-1:0] r_exit_lim;

    logic                  r_in_valid;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_level;

    logic                  r_out_valid;
    logic [VOLTS_W-1:0]    r_volts;
    t_volt_flags           r_volt_flags;
    t_ign_flags            r_ign_flags;

    logic                  advance;
    t_volt_flags           volt_flags;
    t_ign_flags            ign_flags;
    logic [15:0]           sample_x10;
    logic [6:0]            tenths;
    logic [7:0]            rounded;
    logic [15:0]           div_prod;
    logic [VOLTS_W-1:0]    n_volts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= HIGH_THR_RST;
            r_low_thr  <= LOW_THR_RST;
            r_mask_thr <= MASK_THR_RST;
            r_exit_lim <= EXIT_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_HIGH_THR: r_high_thr <= i_cfg_wdata;
                CFG_LOW_THR:  r_low_thr  <= i_cfg_wdata;
                CFG_MASK_THR: r_mask_thr <= i_cfg_wdata;
                CFG_EXIT_LIM: r_exit_lim <= i_cfg_wdata[EXIT_LIM_W-1:0];
            endcase
        end
    end

    // item moves from input register to result register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_level  <= s_axis_tdata[SAMPLE_W];
        end
    end

    svim_volt_mon #(
        .VOLT_WINDOW (VOLT_WINDOW)
    ) u_volt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_sample   (r_sample),
        .i_high_thr (r_high_thr),
        .i_low_thr  (r_low_thr),
        .i_mask_thr (r_mask_thr),
        .i_exit_lim (r_exit_lim),
        .o_flags    (volt_flags)
    );

    svim_ign_mon #(
        .IG_WINDOW (IG_WINDOW)
    ) u_ign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_level (r_level),
        .o_flags (ign_flags)
    );

    // ((s*10 >> 9) + 8) / 10, the divide by 10 as *205 >> 11 (exact below 1029)
    assign sample_x10 = {r_sample, 3'b000} + {3'b000, r_sample, 1'b0};
    assign tenths     = sample_x10[15:9];
    assign rounded    = {1'b0, tenths} + 8'd8;
    assign div_prod   = rounded * 8'd205;
    assign n_volts    = div_prod[14:11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_volts      <= n_volts;
            r_volt_flags <= volt_flags;
            r_ign_flags  <= ign_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_ign_flags.off_seen,
                            r_ign_flags.on,
                            r_volt_flags.mask,
                            r_volt_flags.under,
                            r_volt_flags.over,
                            r_volts};

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled while result register is empty");

endmodule
